// ===== design/dro_pkg.sv =====
package dro_pkg;

    localparam int MAX_CLASSES_DEF = 128;
    localparam int BOX_LEN         = 4;

    localparam int VALUE_W    = 19;
    localparam int CLASS_W    = 7;
    localparam int COORD_W    = 16;
    localparam int CC_W       = 8;
    localparam int THR_W      = 17;
    localparam int FRAME_W    = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // 2*centre +/- size, then times frame size (units of 2^-17 pixel)
    localparam int SUM_W  = VALUE_W + 2;
    localparam int PROD_W = SUM_W + FRAME_W + 1;
    localparam int FRAC_W = 17;
    localparam int RND_W  = PROD_W + 1 - FRAC_W;

    localparam logic [CC_W-1:0]    CLASS_COUNT_RST = CC_W'(80);
    localparam logic [THR_W-1:0]   THRESHOLD_RST   = THR_W'(32768);
    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST = FRAME_W'(640);
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = FRAME_W'(640);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLASS_COUNT     = 2'd0,
        REG_SCORE_THRESHOLD = 2'd1,
        REG_FRAME_WIDTH     = 2'd2,
        REG_FRAME_HEIGHT    = 2'd3
    } cfg_reg_t;

    // floor((p + 2^16) / 2^17), saturated to a 16-bit signed pixel coordinate
    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W:0]  t;
        logic signed [RND_W-1:0] r;
        t = $signed({p[PROD_W-1], p}) + $signed((PROD_W+1)'(65536));
        r = t[PROD_W:FRAC_W];
        if (r[RND_W-1:COORD_W-1] == '0 || r[RND_W-1:COORD_W-1] == '1) begin
            round_sat = r[COORD_W-1:0];
        end else if (r[RND_W-1]) begin
            round_sat = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            round_sat = {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== design/detection_row_decode.sv =====
// Channel   Direction  Ports                                   Moves
// s_        in         s_valid s_ready s_value                 one tensor element per request
// m_        out        m_valid m_ready m_class_index ..        one detection per request
// cfg_      in         cfg_we cfg_index cfg_data               register write, no wait
//
// One element is taken every cycle while s_ready is high; each needs one compare and a register store.
// After the row's last element a detection passes through the sum register,
// the multiplier register, then round/saturate/order into the output register.
// aresetn is synchronous, active low; it clears the row position, the pipeline
// valids and loads the register defaults.
// With m_ready low the pipeline holds up to three detections before s_ready drops.
module detection_row_decode #(
    parameter int MAX_CLASSES = dro_pkg::MAX_CLASSES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [dro_pkg::VALUE_W-1:0]    s_value,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [dro_pkg::CLASS_W-1:0]           m_class_index,
    output logic signed [dro_pkg::VALUE_W-1:0]    m_best_score,
    output logic signed [dro_pkg::COORD_W-1:0]    m_left,
    output logic signed [dro_pkg::COORD_W-1:0]    m_top,
    output logic signed [dro_pkg::COORD_W-1:0]    m_right,
    output logic signed [dro_pkg::COORD_W-1:0]    m_bottom,

    input  logic                                  cfg_we,
    input  logic [dro_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dro_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int POS_W = $clog2(MAX_CLASSES + dro_pkg::BOX_LEN);
    localparam int VW    = dro_pkg::VALUE_W;
    localparam int SW    = dro_pkg::SUM_W;
    localparam int PW    = dro_pkg::PROD_W;
    localparam int CW    = dro_pkg::COORD_W;
    localparam int KW    = dro_pkg::CLASS_W;

    // configuration
    logic [dro_pkg::CC_W-1:0]    class_count_reg;
    logic [dro_pkg::THR_W-1:0]   threshold_reg;
    logic [dro_pkg::FRAME_W-1:0] frame_width_reg;
    logic [dro_pkg::FRAME_W-1:0] frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_count_reg  <= dro_pkg::CLASS_COUNT_RST;
            threshold_reg    <= dro_pkg::THRESHOLD_RST;
            frame_width_reg  <= dro_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= dro_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (dro_pkg::cfg_reg_t'(cfg_index))
                dro_pkg::REG_CLASS_COUNT:     class_count_reg  <= cfg_data[dro_pkg::CC_W-1:0];
                dro_pkg::REG_SCORE_THRESHOLD: threshold_reg    <= cfg_data[dro_pkg::THR_W-1:0];
                dro_pkg::REG_FRAME_WIDTH:     frame_width_reg  <= cfg_data[dro_pkg::FRAME_W-1:0];
                dro_pkg::REG_FRAME_HEIGHT:    frame_height_reg <= cfg_data[dro_pkg::FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic job_valid_reg, prod_valid_reg, m_valid_reg;
    logic out_ready, prod_ready, prod_adv, job_ready, job_adv, accept, emit;

    assign out_ready  = !m_valid_reg || m_ready;
    assign prod_adv   = prod_valid_reg && out_ready;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign job_adv    = job_valid_reg && prod_ready;
    assign job_ready  = !job_valid_reg || prod_ready;
    assign s_ready    = job_ready;
    assign accept     = s_valid && s_ready;

    // row tracking
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic signed [VW-1:0] box_reg [dro_pkg::BOX_LEN];
    logic signed [VW-1:0] best_score_reg, row_score;
    logic [KW-1:0]        best_class_reg, row_class;
    logic [8:0]           eff_cc;
    logic [POS_W-1:0]     last_pos;
    logic                 in_box, row_end, take_new, pass;

    always_comb begin
        if (class_count_reg == '0) begin
            eff_cc = 9'd1;
        end else if ({1'b0, class_count_reg} > 9'(MAX_CLASSES)) begin
            eff_cc = 9'(MAX_CLASSES);
        end else begin
            eff_cc = {1'b0, class_count_reg};
        end
    end

    assign last_pos = POS_W'(eff_cc) + POS_W'(dro_pkg::BOX_LEN - 1);
    assign in_box   = pos_reg < POS_W'(dro_pkg::BOX_LEN);
    assign row_end  = !in_box && !(pos_reg < last_pos);
    // first score of a row always loads; later ones only when strictly larger
    assign take_new = (pos_reg == POS_W'(dro_pkg::BOX_LEN)) || (s_value > best_score_reg);
    assign row_score = take_new ? s_value : best_score_reg;
    assign row_class = take_new ? KW'(pos_reg - POS_W'(dro_pkg::BOX_LEN)) : best_class_reg;
    assign pass      = $signed({row_score[VW-1], row_score})
                       >= $signed({3'b000, threshold_reg});
    assign emit      = accept && row_end && pass;

    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            pos_next = row_end ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && in_box) begin
            box_reg[pos_reg[1:0]] <= s_value;
        end
        if (accept && !in_box) begin
            best_score_reg <= row_score;
            best_class_reg <= row_class;
        end
    end

    // stage 1: corner sums
    logic signed [SW-1:0] x1_reg, x2_reg, y1_reg, y2_reg;
    logic signed [VW-1:0] job_score_reg;
    logic [KW-1:0]        job_class_reg;
    logic signed [SW-1:0] cx2, cy2;

    assign cx2 = SW'(box_reg[0]) <<< 1;
    assign cy2 = SW'(box_reg[1]) <<< 1;

    always_ff @(posedge aclk) begin
        if (emit) begin
            x1_reg        <= cx2 - SW'(box_reg[2]);
            x2_reg        <= cx2 + SW'(box_reg[2]);
            y1_reg        <= cy2 - SW'(box_reg[3]);
            y2_reg        <= cy2 + SW'(box_reg[3]);
            job_score_reg <= row_score;
            job_class_reg <= row_class;
        end
    end

    // stage 2: scale by frame size
    logic signed [PW-1:0] px1_reg, px2_reg, py1_reg, py2_reg;
    logic signed [VW-1:0] prod_score_reg;
    logic [KW-1:0]        prod_class_reg;
    logic signed [PW-1:0] fw, fh;

    assign fw = PW'($signed({1'b0, frame_width_reg}));
    assign fh = PW'($signed({1'b0, frame_height_reg}));

    always_ff @(posedge aclk) begin
        if (job_adv) begin
            px1_reg        <= PW'(x1_reg) * fw;
            px2_reg        <= PW'(x2_reg) * fw;
            py1_reg        <= PW'(y1_reg) * fh;
            py2_reg        <= PW'(y2_reg) * fh;
            prod_score_reg <= job_score_reg;
            prod_class_reg <= job_class_reg;
        end
    end

    // stage 3: round, saturate, order
    logic signed [CW-1:0] rx1, rx2, ry1, ry2;

    assign rx1 = dro_pkg::round_sat(px1_reg);
    assign rx2 = dro_pkg::round_sat(px2_reg);
    assign ry1 = dro_pkg::round_sat(py1_reg);
    assign ry2 = dro_pkg::round_sat(py2_reg);

    always_ff @(posedge aclk) begin
        if (prod_adv) begin
            m_class_index <= prod_class_reg;
            m_best_score  <= prod_score_reg;
            m_left        <= (rx1 < rx2) ? rx1 : rx2;
            m_right       <= (rx1 < rx2) ? rx2 : rx1;
            m_top         <= (ry1 < ry2) ? ry1 : ry2;
            m_bottom      <= (ry1 < ry2) ? ry2 : ry1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (emit) begin
                job_valid_reg <= 1'b1;
            end else if (job_adv) begin
                job_valid_reg <= 1'b0;
            end
            if (job_adv) begin
                prod_valid_reg <= 1'b1;
            end else if (prod_adv) begin
                prod_valid_reg <= 1'b0;
            end
            if (prod_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (job_valid_reg && prod_valid_reg && m_valid_reg))
        else $error("input stalled while pipeline not full");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_CLASSES + dro_pkg::BOX_LEN - 1))
        else $error("row position beyond last element");

    a_job_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        job_adv |=> prod_valid_reg)
        else $error("scaled request lost");

    a_x_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_left <= m_right && m_top <= m_bottom))
        else $error("corners out of order");
`endif

endmodule
